/* sv/mcc_pkg.sv */
`default_nettype none
package mcc_pkg;

  localparam int DATA_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int KERNEL     = 3;
  localparam int MAX_HEIGHT = 1024;

  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_IN_CH  = 8;
  localparam int DEF_MAX_OUT_CH = 16;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELU_ENABLE  = 3'd4;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tap_ctl_t;

endpackage
`default_nettype wire

/* sv/mcc_ram.sv */
`default_nettype none
module mcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/mcc_mac.sv */
`default_nettype none
module mcc_mac #(
  parameter int MAX_IN_CH = mcc_pkg::DEF_MAX_IN_CH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mcc_pkg::tap_ctl_t                  tap,
  input  wire logic signed [mcc_pkg::DATA_W-1:0]  sample_data,
  input  wire logic signed [mcc_pkg::DATA_W-1:0]  weight_data,
  input  wire logic signed [mcc_pkg::DATA_W-1:0]  bias_data,
  input  wire logic                               relu_enable,
  output logic                                    done,
  output logic signed [mcc_pkg::DATA_W-1:0]       result
);

  localparam int NTERMS = MAX_IN_CH * mcc_pkg::KERNEL * mcc_pkg::KERNEL;
  localparam int ACC_W  = 2 * mcc_pkg::DATA_W + $clog2(NTERMS + 1);
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((1 <<< (mcc_pkg::DATA_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);

  mcc_pkg::tap_ctl_t                   p_ctl;
  logic signed [2*mcc_pkg::DATA_W-1:0] prod;
  logic signed [mcc_pkg::DATA_W-1:0]   bias_r;
  logic signed [ACC_W-1:0]             acc;
  logic signed [ACC_W-1:0]             bias_x;
  logic signed [ACC_W-1:0]             shifted;
  logic signed [ACC_W-1:0]             clipped;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
      done  <= 1'b0;
    end else begin
      p_ctl <= tap;
      done  <= p_ctl.valid & p_ctl.last;
    end
    prod   <= sample_data * weight_data;
    bias_r <= bias_data;
    if (p_ctl.valid) begin
      acc <= (p_ctl.first ? bias_x : acc) + ACC_W'(prod);
    end
  end

  always_comb begin
    bias_x  = ACC_W'(bias_r) <<< mcc_pkg::FRAC_W;
    shifted = acc >>> mcc_pkg::FRAC_W;
    clipped = shifted;
    if (relu_enable && shifted < 0) begin
      clipped = '0;
    end
    if (clipped > MAXV) begin
      clipped = MAXV;
    end else if (clipped < MINV) begin
      clipped = MINV;
    end
    result = clipped[mcc_pkg::DATA_W-1:0];
  end

endmodule
`default_nettype wire

/* sv/multichannel_conv2d_bias_relu.sv */
// 3x3 valid convolution engine, stride 1, multichannel, bias and optional relu.
// item channel (item_valid / item_stall): one command beat at a time. weight and
// bias loads, and samples that do not close a window, leave item_stall low.
// samples arrive in raster order, channel fastest; the last channel of a pixel at
// row and column 2 or more starts a window pass.
// a window pass computes one result per output channel, in channel order, with a
// single multiply-accumulate unit fed from the line, weight and bias memories, one
// tap per cycle; item_stall is high for the whole pass.
// result channel (result_valid / result_stall): one output register; while the
// receiver stalls a finished result waits there and the pass holds before it.
// config port: cfg_write, cfg_index, cfg_data; write only while idle.
// reset clears the counters, the pass and the output register and restores the
// default configuration; weights, biases and line data hold nothing until loaded.
`default_nettype none
module multichannel_conv2d_bias_relu #(
  parameter int MAX_WIDTH  = mcc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_IN_CH  = mcc_pkg::DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = mcc_pkg::DEF_MAX_OUT_CH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [mcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mcc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 item_valid,
  output logic                                      item_stall,
  input  wire logic [1:0]                           command,
  input  wire logic [3:0]                           target_channel,
  input  wire logic [2:0]                           source_channel,
  input  wire logic [1:0]                           tap_row,
  input  wire logic [1:0]                           tap_col,
  input  wire logic signed [mcc_pkg::DATA_W-1:0]    data_value,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic [3:0]                                result_channel,
  output logic [9:0]                                result_row,
  output logic [4:0]                                result_col,
  output logic signed [mcc_pkg::DATA_W-1:0]         result_value,
  output logic                                      last_of_run
);

  localparam int K      = mcc_pkg::KERNEL;
  localparam int COL_W  = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int CH_W   = MAX_IN_CH > 1 ? $clog2(MAX_IN_CH) : 1;
  localparam int OC_W   = MAX_OUT_CH > 1 ? $clog2(MAX_OUT_CH) : 1;
  localparam int TAP_W  = K > 1 ? $clog2(K) : 1;
  localparam int L_DEP  = K * MAX_WIDTH * MAX_IN_CH;
  localparam int W_DEP  = MAX_OUT_CH * MAX_IN_CH * K * K;
  localparam int LA_W   = L_DEP > 1 ? $clog2(L_DEP) : 1;
  localparam int WA_W   = W_DEP > 1 ? $clog2(W_DEP) : 1;
  localparam int BA_W   = OC_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_EMIT} state_t;

  state_t state;

  logic [5:0]  image_width;
  logic [10:0] image_height;
  logic [3:0]  in_channels;
  logic [4:0]  out_channels;
  logic        relu_enable;

  logic [10:0] w_last;
  logic [10:0] h_last;
  logic [6:0]  nin_last;
  logic [6:0]  nout_last;

  logic [COL_W-1:0] column_count;
  logic [9:0]       row_count;
  logic [CH_W-1:0]  channel_count;
  logic [TAP_W-1:0] row_ph;

  logic item_accept;
  logic is_sample;
  logic trigger;

  // window pass registers
  logic [9:0]       row_q;
  logic [COL_W-1:0] col_q;
  logic [TAP_W-1:0] ph_q;
  logic [OC_W-1:0]  oc_q;
  logic [CH_W-1:0]  ic_q;
  logic [TAP_W-1:0] a_q;
  logic [TAP_W-1:0] b_q;
  logic [TAP_W:0]   slot_sum;
  logic [TAP_W-1:0] slot;
  logic [COL_W-1:0] col_tap;

  logic             line_we;
  logic [LA_W-1:0]  line_waddr;
  logic [LA_W-1:0]  line_raddr;
  logic             weight_we;
  logic [WA_W-1:0]  weight_waddr;
  logic [WA_W-1:0]  weight_raddr;
  logic             bias_we;
  logic [BA_W-1:0]  bias_waddr;

  logic [mcc_pkg::DATA_W-1:0] line_rdata;
  logic [mcc_pkg::DATA_W-1:0] weight_rdata;
  logic [mcc_pkg::DATA_W-1:0] bias_rdata;

  mcc_pkg::tap_ctl_t issue;
  mcc_pkg::tap_ctl_t d1;
  logic              mac_done;
  logic signed [mcc_pkg::DATA_W-1:0] mac_result;
  logic              out_free;

  // registers clamped into range on use
  always_comb begin
    w_last    = 11'((image_width < K) ? K :
                    (image_width > MAX_WIDTH) ? MAX_WIDTH : int'(image_width)) - 11'd1;
    h_last    = 11'((image_height < K) ? K :
                    (image_height > mcc_pkg::MAX_HEIGHT) ? mcc_pkg::MAX_HEIGHT :
                    int'(image_height)) - 11'd1;
    nin_last  = 7'((in_channels < 1) ? 1 :
                   (in_channels > MAX_IN_CH) ? MAX_IN_CH : int'(in_channels)) - 7'd1;
    nout_last = 7'((out_channels < 1) ? 1 :
                   (out_channels > MAX_OUT_CH) ? MAX_OUT_CH : int'(out_channels)) - 7'd1;
  end

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid & ~item_stall;
  assign is_sample   = item_accept && (command == mcc_pkg::CMD_SAMPLE);
  assign trigger     = is_sample && (channel_count >= nin_last) &&
                       (row_count >= 10'(K - 1)) && (column_count >= COL_W'(K - 1));

  // write side of the stores
  always_comb begin
    line_we      = is_sample;
    line_waddr   = LA_W'((int'(row_ph) * MAX_WIDTH + int'(column_count)) * MAX_IN_CH
                         + int'(channel_count));
    weight_we    = item_accept && (command == mcc_pkg::CMD_WEIGHT) &&
                   (tap_row < K) && (tap_col < K) &&
                   (target_channel < MAX_OUT_CH) && (source_channel < MAX_IN_CH);
    weight_waddr = WA_W'(((int'(target_channel) * MAX_IN_CH + int'(source_channel)) * K
                          + int'(tap_row)) * K + int'(tap_col));
    bias_we      = item_accept && (command == mcc_pkg::CMD_BIAS) &&
                   (target_channel < MAX_OUT_CH);
    bias_waddr   = BA_W'(target_channel);
  end

  // read side: ring slot of the tap row and its column
  always_comb begin
    slot_sum     = (TAP_W + 1)'(ph_q) + (TAP_W + 1)'(a_q) + (TAP_W + 1)'(1);
    slot         = (slot_sum >= (TAP_W + 1)'(K)) ? TAP_W'(slot_sum - (TAP_W + 1)'(K))
                                                 : TAP_W'(slot_sum);
    col_tap      = COL_W'(int'(col_q) - (K - 1) + int'(b_q));
    line_raddr   = LA_W'((int'(slot) * MAX_WIDTH + int'(col_tap)) * MAX_IN_CH + int'(ic_q));
    weight_raddr = WA_W'(((int'(oc_q) * MAX_IN_CH + int'(ic_q)) * K + int'(a_q)) * K
                         + int'(b_q));
    issue.valid  = (state == S_RUN);
    issue.first  = (ic_q == '0) && (a_q == '0) && (b_q == '0);
    issue.last   = (ic_q == CH_W'(nin_last)) && (a_q == TAP_W'(K - 1)) &&
                   (b_q == TAP_W'(K - 1));
  end

  assign out_free = ~result_valid | ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 6'd28;
      image_height <= 11'd28;
      in_channels  <= 4'd1;
      out_channels <= 5'd8;
      relu_enable  <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mcc_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[5:0];
        mcc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[10:0];
        mcc_pkg::REG_IN_CHANNELS:  in_channels  <= cfg_data[3:0];
        mcc_pkg::REG_OUT_CHANNELS: out_channels <= cfg_data[4:0];
        mcc_pkg::REG_RELU_ENABLE:  relu_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      channel_count <= '0;
      row_ph        <= '0;
    end else if (is_sample) begin
      if (channel_count >= nin_last) begin
        channel_count <= '0;
        if (column_count >= w_last) begin
          column_count <= '0;
          if (row_count >= h_last) begin
            row_count <= '0;
            row_ph    <= '0;
          end else begin
            row_count <= row_count + 10'd1;
            row_ph    <= (row_ph == TAP_W'(K - 1)) ? '0 : row_ph + TAP_W'(1);
          end
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end else begin
        channel_count <= channel_count + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
    end else begin
      d1 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (trigger) begin
            state <= S_RUN;
            row_q <= row_count;
            col_q <= column_count;
            ph_q  <= row_ph;
            oc_q  <= '0;
            ic_q  <= '0;
            a_q   <= '0;
            b_q   <= '0;
          end
        end
        S_RUN: begin
          if (b_q == TAP_W'(K - 1)) begin
            b_q <= '0;
            if (a_q == TAP_W'(K - 1)) begin
              a_q <= '0;
              if (ic_q == CH_W'(nin_last)) begin
                ic_q  <= '0;
                state <= S_DRAIN;
              end else begin
                ic_q <= ic_q + CH_W'(1);
              end
            end else begin
              a_q <= a_q + TAP_W'(1);
            end
          end else begin
            b_q <= b_q + TAP_W'(1);
          end
        end
        S_DRAIN: begin
          if (mac_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            result_channel <= 4'(oc_q);
            result_row     <= 10'(int'(row_q) - (K - 1));
            result_col     <= 5'(int'(col_q) - (K - 1));
            result_value   <= mac_result;
            last_of_run    <= (7'(oc_q) == nout_last);
            if (7'(oc_q) == nout_last) begin
              state <= S_IDLE;
            end else begin
              oc_q  <= oc_q + OC_W'(1);
              state <= S_RUN;
            end
          end else if (result_valid && !result_stall) begin
            result_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mcc_ram #(.WIDTH(mcc_pkg::DATA_W), .DEPTH(L_DEP)) u_line_ram (
    .clk  (clk),
    .we   (line_we),
    .waddr(line_waddr),
    .wdata(data_value),
    .raddr(line_raddr),
    .rdata(line_rdata)
  );

  mcc_ram #(.WIDTH(mcc_pkg::DATA_W), .DEPTH(W_DEP)) u_weight_ram (
    .clk  (clk),
    .we   (weight_we),
    .waddr(weight_waddr),
    .wdata(data_value),
    .raddr(weight_raddr),
    .rdata(weight_rdata)
  );

  mcc_ram #(.WIDTH(mcc_pkg::DATA_W), .DEPTH(MAX_OUT_CH)) u_bias_ram (
    .clk  (clk),
    .we   (bias_we),
    .waddr(bias_waddr),
    .wdata(data_value),
    .raddr(oc_q),
    .rdata(bias_rdata)
  );

  mcc_mac #(.MAX_IN_CH(MAX_IN_CH)) u_mac (
    .clk        (clk),
    .rst        (rst),
    .tap        (d1),
    .sample_data($signed(line_rdata)),
    .weight_data($signed(weight_rdata)),
    .bias_data  ($signed(bias_rdata)),
    .relu_enable(relu_enable),
    .done       (mac_done),
    .result     (mac_result)
  );

endmodule
`default_nettype wire

/* tb/sv/multichannel_conv2d_bias_relu_checker.sv */
`default_nettype none
module multichannel_conv2d_bias_relu_checker
  import mcc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     item_valid,
  input  wire logic                     item_stall,
  input  wire logic [1:0]               command,
  input  wire logic [3:0]               target_channel,
  input  wire logic [2:0]               source_channel,
  input  wire logic [1:0]               tap_row,
  input  wire logic [1:0]               tap_col,
  input  wire logic signed [DATA_W-1:0] data_value,
  input  wire logic                     result_valid,
  input  wire logic                     result_stall,
  input  wire logic [3:0]               result_channel,
  input  wire logic [9:0]               result_row,
  input  wire logic [4:0]               result_col,
  input  wire logic signed [DATA_W-1:0] result_value,
  input  wire logic                     last_of_run,
  output int                            pending,
  output int                            errors
);

  typedef struct packed {
    logic [3:0]               ch;
    logic [9:0]               row;
    logic [4:0]               col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } conv_out_t;

  conv_out_t conv_q[$];

  logic signed [DATA_W-1:0] kernel_mem [16][8][3][3];
  logic signed [DATA_W-1:0] bias_mem [16];
  logic signed [DATA_W-1:0] line_mem [3][32][8];

  logic [5:0]  width_reg;
  logic [10:0] height_reg;
  logic [3:0]  in_ch_reg;
  logic [4:0]  out_ch_reg;
  logic        relu_reg;
  logic [4:0]  col_cnt;
  logic [9:0]  row_cnt;
  logic [2:0]  ch_cnt;
  int          mismatches;

  function automatic int clamp_int(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic take_sample(logic signed [DATA_W-1:0] v);
    int w, h, nin, nout, rr, cc;
    longint acc;
    conv_out_t o;
    w    = clamp_int(width_reg, 3, 32);
    h    = clamp_int(height_reg, 3, 1024);
    nin  = clamp_int(in_ch_reg, 1, 8);
    nout = clamp_int(out_ch_reg, 1, 16);
    rr   = row_cnt;
    cc   = col_cnt;
    line_mem[rr % 3][cc][ch_cnt] = v;
    if (ch_cnt >= nin - 1) begin
      if (rr >= 2 && cc >= 2) begin
        for (int oc = 0; oc < nout; oc++) begin
          acc = longint'(bias_mem[oc]) * 256;
          for (int ic = 0; ic < nin; ic++)
            for (int a = 0; a < 3; a++)
              for (int b = 0; b < 3; b++)
                acc += longint'(line_mem[(rr + 1 + a) % 3][cc - 2 + b][ic]) *
                       longint'(kernel_mem[oc][ic][a][b]);
          acc = acc >>> FRAC_W;
          if (relu_reg && acc < 0) acc = 0;
          if (acc > 32767) acc = 32767;
          if (acc < -32768) acc = -32768;
          o.ch    = 4'(oc);
          o.row   = 10'(rr - 2);
          o.col   = 5'(cc - 2);
          o.value = DATA_W'(acc);
          o.last  = (oc == nout - 1);
          conv_q = {conv_q, o};
        end
      end
      ch_cnt = 0;
      if (col_cnt >= w - 1) begin
        col_cnt = 0;
        row_cnt = (row_cnt >= h - 1) ? 10'd0 : row_cnt + 10'd1;
      end else begin
        col_cnt = col_cnt + 5'd1;
      end
    end else begin
      ch_cnt = ch_cnt + 3'd1;
    end
  endtask

  always @(posedge clk) begin
    conv_out_t e;
    if (rst) begin
      width_reg  = 6'd28;
      height_reg = 11'd28;
      in_ch_reg  = 4'd1;
      out_ch_reg = 5'd8;
      relu_reg   = 1'b1;
      col_cnt    = '0;
      row_cnt    = '0;
      ch_cnt     = '0;
      mismatches = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (conv_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ch %0d row %0d col %0d value %0d last %0d",
                     result_channel, result_row, result_col, result_value, last_of_run);
        end else begin
          e = conv_q.pop_front();
          if (e.ch !== result_channel || e.row !== result_row || e.col !== result_col ||
              e.value !== result_value || e.last !== last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected ch %0d row %0d col %0d value %0d last %0d",
                       e.ch, e.row, e.col, e.value, e.last);
              $display("  got ch %0d row %0d col %0d value %0d last %0d", result_channel,
                       result_row, result_col, result_value, last_of_run);
            end
          end
        end
      end
      if (item_valid && !item_stall) begin
        case (command)
          CMD_WEIGHT:
            if (tap_row < 3 && tap_col < 3)
              kernel_mem[target_channel][source_channel][tap_row][tap_col] = data_value;
          CMD_BIAS:   bias_mem[target_channel] = data_value;
          CMD_SAMPLE: take_sample(data_value);
          default: ;
        endcase
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data[5:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_data[10:0];
          REG_IN_CHANNELS:  in_ch_reg  = cfg_data[3:0];
          REG_OUT_CHANNELS: out_ch_reg = cfg_data[4:0];
          REG_RELU_ENABLE:  relu_reg   = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending <= conv_q.size();
    errors  <= mismatches;
  end

endmodule
`default_nettype wire

/* tb/sv/multichannel_conv2d_bias_relu_test.sv */
`default_nettype none
module multichannel_conv2d_bias_relu_test;
  import mcc_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic [1:0]               command = '0;
  logic [3:0]               target_channel = '0;
  logic [2:0]               source_channel = '0;
  logic [1:0]               tap_row = '0;
  logic [1:0]               tap_col = '0;
  logic signed [DATA_W-1:0] data_value = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [3:0]               result_channel;
  logic [9:0]               result_row;
  logic [4:0]               result_col;
  logic signed [DATA_W-1:0] result_value;
  logic                     last_of_run;
  int                       pending;
  int                       errors;

  logic quiet = 1'b0;
  int   n_items = 0;
  int   cur_w, cur_h, cur_in, cur_out;
  bit   have_kernel [16][8];
  bit   have_bias [16];

  always #10 clk = ~clk;

  multichannel_conv2d_bias_relu uut (.*);

  multichannel_conv2d_bias_relu_checker chk (.*);

  function automatic int clamp_int(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3, 4: return DATA_W'($urandom_range(0, 1023) - 512);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [1:0] c, logic [3:0] t, logic [2:0] s, logic [1:0] r,
                           logic [1:0] k, logic signed [DATA_W-1:0] v);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_valid     <= 1'b1;
    command        <= c;
    target_channel <= t;
    source_channel <= s;
    tap_row        <= r;
    tap_col        <= k;
    data_value     <= v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    n_items++;
  endtask

  // loads and unused commands with random fields, any of them harmless to the frame
  task automatic send_noise();
    logic [1:0] c;
    c = $urandom_range(0, 2) == 0 ? 2'd3 : ($urandom_range(0, 1) ? CMD_WEIGHT : CMD_BIAS);
    send_item(c, 4'($urandom), 3'($urandom), 2'($urandom), 2'($urandom), rand_val());
  endtask

  task automatic send_sample(logic signed [DATA_W-1:0] v);
    send_item(CMD_SAMPLE, 4'($urandom), 3'($urandom), 2'($urandom), 2'($urandom), v);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(v);
    @(posedge clk);
  endtask

  task automatic configure(int w, int h, int nin, int nout, int relu);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_IN_CHANNELS, nin);
    write_reg(REG_OUT_CHANNELS, nout);
    write_reg(REG_RELU_ENABLE, relu);
    cfg_write <= 1'b0;
    cur_w   = clamp_int(w & 63, 3, 32);
    cur_h   = clamp_int(h & 2047, 3, 1024);
    cur_in  = clamp_int(nin & 15, 1, 8);
    cur_out = clamp_int(nout & 31, 1, 16);
  endtask

  // every kernel and bias a window of this setting reads must hold a value
  task automatic load_kernels();
    for (int oc = 0; oc < cur_out; oc++) begin
      for (int ic = 0; ic < cur_in; ic++)
        if (!have_kernel[oc][ic]) begin
          for (int t = 0; t < 9; t++)
            send_item(CMD_WEIGHT, 4'(oc), 3'(ic), 2'(t / 3), 2'(t % 3), rand_val());
          have_kernel[oc][ic] = 1'b1;
        end
      if (!have_bias[oc]) begin
        send_item(CMD_BIAS, 4'(oc), 3'($urandom), 2'($urandom), 2'($urandom), rand_val());
        have_bias[oc] = 1'b1;
      end
    end
    repeat ($urandom_range(0, 3)) send_noise();
  endtask

  task automatic run_rows(int rows);
    for (int i = 0; i < rows * cur_w * cur_in; i++) begin
      if ($urandom_range(0, 19) == 0) send_noise();
      send_sample(rand_val());
    end
  endtask

  task automatic wait_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    int w, h, nin, nout;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unused indexes, which store nothing, and a top height value first, overwritten below
    write_reg(3'd5, 2047);
    write_reg(3'd6, 0);
    write_reg(3'd7, 1365);
    write_reg(REG_IMAGE_HEIGHT, 2047);
    configure(3, 3, 1, 2, 0);
    for (int t = 0; t < 9; t++) begin
      send_item(CMD_WEIGHT, 4'd0, 3'd0, 2'(t / 3), 2'(t % 3), 16'sh7fff);
      send_item(CMD_WEIGHT, 4'd1, 3'd0, 2'(t / 3), 2'(t % 3), 16'sh8000);
    end
    send_item(CMD_BIAS, 4'd0, 3'd0, 2'd0, 2'd0, 16'sh7fff);
    send_item(CMD_BIAS, 4'd1, 3'd7, 2'd3, 2'd3, 16'sh8000);
    have_kernel[0][0] = 1'b1;
    have_kernel[1][0] = 1'b1;
    have_bias[0] = 1'b1;
    have_bias[1] = 1'b1;
    // tap outside the kernel and the unused command are both dropped
    send_item(CMD_WEIGHT, 4'd0, 3'd0, 2'd3, 2'd1, 16'sh1234);
    send_item(CMD_WEIGHT, 4'd0, 3'd0, 2'd1, 2'd3, 16'sh1234);
    send_item(2'd3, 4'd15, 3'd7, 2'd3, 2'd3, 16'shffff);
    for (int i = 0; i < 9; i++) send_sample(16'sh7fff);
    wait_drain();

    // widest frame, all output channels, tallest height cut short at a row boundary
    configure(32, 1024, 1, 16, 1);
    load_kernels();
    run_rows(3);
    wait_drain();
    write_reg(REG_IMAGE_HEIGHT, 3);
    cfg_write <= 1'b0;
    run_rows(1);
    wait_drain();

    configure(3, 3, 8, 1, 0);
    load_kernels();
    run_rows(3);
    wait_drain();

    while (n_items < 480) begin
      quiet = (n_items > 440);
      w    = $urandom_range(0, 7) == 0 ?
             ($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(33, 63)) :
             $urandom_range(3, 6);
      h    = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 5);
      nin  = $urandom_range(0, 7) == 0 ?
             ($urandom_range(0, 1) ? 0 : $urandom_range(9, 15)) : $urandom_range(1, 3);
      nout = $urandom_range(0, 7) == 0 ?
             ($urandom_range(0, 1) ? 0 : $urandom_range(17, 31)) : $urandom_range(1, 4);
      configure(w, h, nin, nout, $urandom_range(0, 1));
      load_kernels();
      run_rows(cur_h);
      wait_drain();
    end

    if (errors == 0)
      $display("multichannel_conv2d_bias_relu verification clean");
    else
      $display("multichannel_conv2d_bias_relu verification failed");
    $finish;
  end

  initial begin
    #30000000;
    $display("multichannel_conv2d_bias_relu verification failed");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
sv/mcc_pkg.sv
sv/mcc_ram.sv
sv/mcc_mac.sv
sv/multichannel_conv2d_bias_relu.sv
tb/sv/multichannel_conv2d_bias_relu_checker.sv
tb/sv/multichannel_conv2d_bias_relu_test.sv
